FILE: hdl/pmo_pkg.sv
// ----------------------------------------------------------------------------
// pmo_pkg
// Shared types, codes and constants of the platform mode odometry block.
// ----------------------------------------------------------------------------
package pmo_pkg;

    localparam int ANGLE_BITS_DEF    = 16;
    localparam int VELOCITY_BITS_DEF = 16;
    localparam int CORDIC_STEPS_DEF  = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int THR_W      = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIN_THR     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANG_THR     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_STAND  = 2'd3;

    localparam logic [15:0]      RST_TICK_PERIOD = 16'd3277;
    localparam logic [THR_W-1:0] RST_LIN_THR     = 15'd41;
    localparam logic [THR_W-1:0] RST_ANG_THR     = 15'd205;
    localparam logic [15:0]      RST_AUTO_STAND  = 16'd40;

    localparam logic [1:0] OP_VELOCITY = 2'd0;
    localparam logic [1:0] OP_POSTURE  = 2'd1;
    localparam logic [1:0] OP_TICK     = 2'd2;

    localparam logic [2:0] POS_STAND  = 3'd0;
    localparam logic [2:0] POS_SIT    = 3'd1;
    localparam logic [2:0] POS_LIE    = 3'd2;
    localparam logic [2:0] POS_FREEZE = 3'd3;

    localparam logic [1:0] PST_EXECUTING = 2'd0;
    localparam logic [1:0] PST_READY     = 2'd1;
    localparam logic [1:0] PST_DISABLED  = 2'd2;

    localparam int ITER_W = 5;

    localparam logic [3:0] DP_NONE = 4'd0;
    localparam logic [3:0] DP_INIT = 4'd1;
    localparam logic [3:0] DP_CORD = 4'd2;
    localparam logic [3:0] DP_VDT  = 4'd3;
    localparam logic [3:0] DP_WDT  = 4'd4;
    localparam logic [3:0] DP_PX   = 4'd5;
    localparam logic [3:0] DP_PY   = 4'd6;
    localparam logic [3:0] DP_PH   = 4'd7;
    localparam logic [3:0] DP_HD   = 4'd8;

    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [24:0] INV_TWO_PI  = 25'sd2670177;

    typedef struct packed {
        logic              accept;
        logic [3:0]        step;
        logic [ITER_W-1:0] iter;
        logic              load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic run;
    } t_dp_sts;

    function automatic logic [29:0] atan_turns(input logic [ITER_W-1:0] i);
        logic [29:0] v;
        case (i)
            5'd0:    v = 30'd536870912;
            5'd1:    v = 30'd316933406;
            5'd2:    v = 30'd167458907;
            5'd3:    v = 30'd85004756;
            5'd4:    v = 30'd42667331;
            5'd5:    v = 30'd21354465;
            5'd6:    v = 30'd10679838;
            5'd7:    v = 30'd5340245;
            5'd8:    v = 30'd2670163;
            5'd9:    v = 30'd1335087;
            5'd10:   v = 30'd667544;
            5'd11:   v = 30'd333772;
            5'd12:   v = 30'd166886;
            5'd13:   v = 30'd83443;
            5'd14:   v = 30'd41722;
            5'd15:   v = 30'd20861;
            5'd16:   v = 30'd10430;
            5'd17:   v = 30'd5215;
            5'd18:   v = 30'd2608;
            5'd19:   v = 30'd1304;
            5'd20:   v = 30'd652;
            5'd21:   v = 30'd326;
            5'd22:   v = 30'd163;
            5'd23:   v = 30'd81;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: hdl/platform_mode_odometry_top.sv
// ----------------------------------------------------------------------------
// platform_mode_odometry_top
// Legged platform mode logic with unicycle dead reckoning.
// ----------------------------------------------------------------------------
// Velocity and posture items give no result. A tick that integrates runs the
// iterative CORDIC and then the six steps of the shared multiplier. A tick that
// does not integrate goes from the check straight to the report. One item is in
// work at a time. Synchronous active-low reset restores the config registers
// and clears the mode and odometry state.
module platform_mode_odometry_top import pmo_pkg::*; #(
    parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
    parameter int VELOCITY_BITS = VELOCITY_BITS_DEF,
    parameter int CORDIC_STEPS  = CORDIC_STEPS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // linear_velocity, angular_velocity, posture_code, zero fill
    input  logic [((2*VELOCITY_BITS+3+7)/8)*8-1:0] i_s_tdata,
    // operation
    input  logic [1:0]            i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // standing, moving, controllable, gait_trot, report_linear, report_angular,
    // run_state, position_x, position_y, heading, zero fill
    output logic [((2*VELOCITY_BITS+ANGLE_BITS+70+7)/8)*8-1:0] o_m_tdata
);

    localparam int V     = VELOCITY_BITS;
    localparam int OUT_W = ((2*VELOCITY_BITS+ANGLE_BITS+70+7)/8)*8;

    t_dp_cmd cmd;
    t_dp_sts sts;

    pmo_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_op       (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pmo_datapath #(
        .ANGLE_BITS    (ANGLE_BITS),
        .VELOCITY_BITS (VELOCITY_BITS),
        .OUT_W         (OUT_W)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_op        (i_s_tuser),
        .i_lin       (i_s_tdata[V-1:0]),
        .i_ang       (i_s_tdata[2*V-1:V]),
        .i_posture   (i_s_tdata[2*V+2:2*V]),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_data      (o_m_tdata)
    );

endmodule

FILE: hdl/pmo_ctrl.sv
// ----------------------------------------------------------------------------
// pmo_ctrl
// Sequencer: input handshake, CORDIC iteration count, multiply steps, output.
// ----------------------------------------------------------------------------
module pmo_ctrl import pmo_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [1:0] i_op,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    input  t_dp_sts    i_sts,
    output t_dp_cmd    o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHECK  = 4'd1;
    localparam logic [3:0] S_CORD   = 4'd2;
    localparam logic [3:0] S_VDT    = 4'd3;
    localparam logic [3:0] S_WDT    = 4'd4;
    localparam logic [3:0] S_PX     = 4'd5;
    localparam logic [3:0] S_PY     = 4'd6;
    localparam logic [3:0] S_PH     = 4'd7;
    localparam logic [3:0] S_HD     = 4'd8;
    localparam logic [3:0] S_REPORT = 4'd9;

    localparam int STEPS = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
    localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(STEPS - 1);

    logic [3:0]        r_state, n_state;
    logic [ITER_W-1:0] r_iter, n_iter;
    logic              r_out_valid, n_out_valid;
    logic              accept;

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_valid;

    always_comb begin
        n_state       = r_state;
        n_iter        = r_iter;
        n_out_valid   = r_out_valid && !i_m_tready;
        o_cmd.accept   = accept;
        o_cmd.step     = DP_NONE;
        o_cmd.iter     = r_iter;
        o_cmd.load_out = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_op == OP_TICK) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_iter = '0;
                if (i_sts.run) begin
                    o_cmd.step = DP_INIT;
                    n_state    = S_CORD;
                end else begin
                    n_state = S_REPORT;
                end
            end
            S_CORD: begin
                o_cmd.step = DP_CORD;
                n_iter     = r_iter + 1'b1;
                if (r_iter == LAST_ITER) begin
                    n_state = S_VDT;
                end
            end
            S_VDT: begin
                o_cmd.step = DP_VDT;
                n_state    = S_WDT;
            end
            S_WDT: begin
                o_cmd.step = DP_WDT;
                n_state    = S_PX;
            end
            S_PX: begin
                o_cmd.step = DP_PX;
                n_state    = S_PY;
            end
            S_PY: begin
                o_cmd.step = DP_PY;
                n_state    = S_PH;
            end
            S_PH: begin
                o_cmd.step = DP_PH;
                n_state    = S_HD;
            end
            S_HD: begin
                o_cmd.step = DP_HD;
                n_state    = S_REPORT;
            end
            S_REPORT: begin
                if (!r_out_valid || i_m_tready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_iter      <= n_iter;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: hdl/pmo_datapath.sv
// ----------------------------------------------------------------------------
// pmo_datapath
// Mode state, config registers, CORDIC, shared multiplier and odometry.
// ----------------------------------------------------------------------------
module pmo_datapath import pmo_pkg::*; #(
    parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
    parameter int VELOCITY_BITS = VELOCITY_BITS_DEF,
    parameter int OUT_W         = 136
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [CFG_IDX_W-1:0]            i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]           i_cfg_wdata,
    input  logic [1:0]                      i_op,
    input  logic signed [VELOCITY_BITS-1:0] i_lin,
    input  logic signed [VELOCITY_BITS-1:0] i_ang,
    input  logic [2:0]                      i_posture,
    input  t_dp_cmd                         i_cmd,
    output t_dp_sts                         o_sts,
    output logic [OUT_W-1:0]                o_data
);

    localparam int V     = VELOCITY_BITS;
    localparam int A     = ANGLE_BITS;
    localparam int MA    = V + 17;
    localparam int PW    = MA + 25;
    localparam int DX_W  = PW - 32;
    localparam int SUM_W = ((DX_W > 32) ? DX_W : 32) + 1;
    localparam int MW    = (V > THR_W) ? V : THR_W;

    localparam logic signed [PW-1:0]    RND_POS = PW'(64'd1 << 31);
    localparam logic signed [PW-1:0]    RND_YAW = PW'(64'd1 << (51 - A));
    localparam logic signed [SUM_W-1:0] POS_MAX = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] POS_MIN = SUM_W'(-64'sd2147483648);

    logic [15:0]      r_period, r_ast, r_tick_cnt;
    logic [THR_W-1:0] r_lin_thr, r_ang_thr;
    logic             r_standing, r_moving, r_ctl, r_ast_done;
    logic signed [V-1:0]  r_lin, r_ang;
    logic signed [31:0]   r_px, r_py;
    logic [A-1:0]         r_yaw;
    logic signed [33:0]   r_x, r_y, r_z;
    logic                 r_flip;
    logic signed [23:0]   r_cos, r_sin;
    logic signed [MA-1:0] r_vdt, r_wdt;
    logic signed [PW-1:0] r_prod;
    logic [OUT_W-1:0]     r_out;

    logic [15:0]          n_tick_cnt;
    logic [MW-1:0]        lin_mag, ang_mag;
    logic [31:0]          ang32;
    logic signed [33:0]   xs, ys, at, xf, yf;
    logic signed [MA-1:0] mul_a;
    logic signed [24:0]   mul_b;
    logic signed [PW-1:0] pr_pos, pr_yaw;
    logic signed [DX_W-1:0] dx;
    logic signed [31:0]   pos_sel;
    logic signed [SUM_W-1:0] pos_sum;
    logic signed [31:0]   pos_sat;
    logic [1:0]           pstate;

    assign o_sts.run = r_ctl && r_moving;
    assign o_data    = r_out;

    assign lin_mag = MW'(i_lin[V-1] ? -i_lin : i_lin);
    assign ang_mag = MW'(i_ang[V-1] ? -i_ang : i_ang);
    assign n_tick_cnt = (r_tick_cnt == 16'hFFFF) ? r_tick_cnt : r_tick_cnt + 16'd1;

    assign ang32 = 32'(r_yaw) << (32 - A);
    assign xs    = r_x >>> i_cmd.iter;
    assign ys    = r_y >>> i_cmd.iter;
    assign at    = 34'(atan_turns(i_cmd.iter));
    assign xf    = r_flip ? -r_x : r_x;
    assign yf    = r_flip ? -r_y : r_y;

    always_comb begin
        case (i_cmd.step)
            DP_VDT: begin
                mul_a = {{17{r_lin[V-1]}}, r_lin};
                mul_b = {9'd0, r_period};
            end
            DP_WDT: begin
                mul_a = {{17{r_ang[V-1]}}, r_ang};
                mul_b = {9'd0, r_period};
            end
            DP_PX: begin
                mul_a = r_vdt;
                mul_b = {r_cos[23], r_cos};
            end
            DP_PY: begin
                mul_a = r_vdt;
                mul_b = {r_sin[23], r_sin};
            end
            default: begin
                mul_a = r_wdt;
                mul_b = INV_TWO_PI;
            end
        endcase
    end

    assign pr_pos  = r_prod + RND_POS;
    assign pr_yaw  = r_prod + RND_YAW;
    assign dx      = pr_pos[PW-1:32];
    assign pos_sel = (i_cmd.step == DP_PY) ? r_px : r_py;
    assign pos_sum = {{(SUM_W-32){pos_sel[31]}}, pos_sel}
                   + {{(SUM_W-DX_W){dx[DX_W-1]}}, dx};
    assign pos_sat = (pos_sum > POS_MAX) ? 32'sh7FFFFFFF
                   : (pos_sum < POS_MIN) ? 32'sh80000000 : pos_sum[31:0];
    assign pstate  = r_moving ? PST_EXECUTING : (r_ctl ? PST_READY : PST_DISABLED);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period   <= RST_TICK_PERIOD;
            r_lin_thr  <= RST_LIN_THR;
            r_ang_thr  <= RST_ANG_THR;
            r_ast      <= RST_AUTO_STAND;
            r_standing <= 1'b0;
            r_moving   <= 1'b0;
            r_ctl      <= 1'b0;
            r_ast_done <= 1'b0;
            r_tick_cnt <= '0;
            r_lin      <= '0;
            r_ang      <= '0;
            r_px       <= '0;
            r_py       <= '0;
            r_yaw      <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_TICK_PERIOD: r_period  <= i_cfg_wdata;
                    CFG_LIN_THR:     r_lin_thr <= i_cfg_wdata[THR_W-1:0];
                    CFG_ANG_THR:     r_ang_thr <= i_cfg_wdata[THR_W-1:0];
                    CFG_AUTO_STAND:  r_ast     <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_cmd.accept) begin
                case (i_op)
                    OP_VELOCITY: begin
                        if (r_ctl) begin
                            r_lin    <= i_lin;
                            r_ang    <= i_ang;
                            r_moving <= (lin_mag > MW'(r_lin_thr)) ||
                                        (ang_mag > MW'(r_ang_thr));
                        end
                    end
                    OP_POSTURE: begin
                        case (i_posture)
                            POS_STAND: begin
                                r_standing <= 1'b1;
                                r_ctl      <= 1'b1;
                            end
                            POS_SIT, POS_LIE, POS_FREEZE: begin
                                r_standing <= 1'b0;
                                r_ctl      <= 1'b0;
                                r_lin      <= '0;
                                r_ang      <= '0;
                            end
                            default: ;
                        endcase
                    end
                    OP_TICK: begin
                        r_tick_cnt <= n_tick_cnt;
                        if (!r_ast_done && n_tick_cnt >= r_ast) begin
                            r_ast_done <= 1'b1;
                            if (!r_standing) begin
                                r_standing <= 1'b1;
                                r_ctl      <= 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            case (i_cmd.step)
                DP_PY:   r_px  <= pos_sat;
                DP_PH:   r_py  <= pos_sat;
                DP_HD:   r_yaw <= r_yaw + pr_yaw[51:52-A];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (i_cmd.step)
            DP_INIT: begin
                r_flip <= ang32[31] ^ ang32[30];
                r_x    <= CORDIC_GAIN;
                r_y    <= '0;
                r_z    <= {{2{ang32[31] ^ ang32[31] ^ ang32[30]}},
                           ang32[31] ^ ang32[30] ^ ang32[31], ang32[30:0]};
            end
            DP_CORD: begin
                if (!r_z[33]) begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - at;
                end else begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + at;
                end
            end
            DP_VDT: begin
                r_cos <= 24'((xf + 34'sd512) >>> 10);
                r_sin <= 24'((yf + 34'sd512) >>> 10);
            end
            DP_WDT:  r_vdt <= r_prod[MA-1:0];
            DP_PX:   r_wdt <= r_prod[MA-1:0];
            default: ;
        endcase
        if (i_cmd.load_out) begin
            r_out <= OUT_W'({r_yaw, r_py, r_px, pstate, r_ang, r_lin,
                             r_moving, r_ctl, r_moving, r_standing});
        end
    end

endmodule
